[rtl/aes_pkg.sv]
// Package with AES constants, S-boxes and round functions.
package aes_pkg;

    localparam int unsigned NumWords = 44;
    localparam int unsigned WordAw   = 6;

    typedef enum logic [2:0] {
        REG_DECRYPT = 3'd0,
        REG_KEY_HI  = 3'd1,
        REG_KEY_LO  = 3'd2,
        REG_IV_HI   = 3'd3,
        REG_IV_LO   = 3'd4
    } reg_idx_t;

    typedef logic [7:0] byte_t;

    localparam byte_t FWD_BOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam byte_t REV_BOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam byte_t RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic byte_t xt(input byte_t b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Column byte r of state word c sits at bits 127-32c-8r.
    function automatic byte_t sb(input logic [127:0] s, input int c, input int r);
        return s[127 - 32*c - 8*r -: 8];
    endfunction

    function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic last);
        logic [127:0] t;
        logic [127:0] m;
        byte_t a0, a1, a2, a3;
        t = '0;
        m = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 32*c - 8*r -: 8] = FWD_BOX[sb(s, (c + r) % 4, r)];
        for (int c = 0; c < 4; c++) begin
            a0 = sb(t, c, 0); a1 = sb(t, c, 1); a2 = sb(t, c, 2); a3 = sb(t, c, 3);
            m[127 - 32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                   xt(a1) ^ xt(a2) ^ a2 ^ a3 ^ a0,
                                   xt(a2) ^ xt(a3) ^ a3 ^ a0 ^ a1,
                                   xt(a3) ^ xt(a0) ^ a0 ^ a1 ^ a2};
        end
        return last ? t : m;
    endfunction

    // Inverse shift and substitution, to be applied after the key add.
    function automatic logic [127:0] rev_sub(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127 - 32*((c + r) % 4) - 8*r -: 8] = REV_BOX[sb(s, c, r)];
        return t;
    endfunction

    function automatic logic [127:0] rev_mix(input logic [127:0] s);
        logic [127:0] m;
        byte_t a [4];
        byte_t x2 [4];
        byte_t x4 [4];
        byte_t x8 [4];
        byte_t e9 [4];
        byte_t eb [4];
        byte_t ed [4];
        byte_t ee [4];
        m = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                a[i]  = sb(s, c, i);
                x2[i] = xt(a[i]);
                x4[i] = xt(x2[i]);
                x8[i] = xt(x4[i]);
                e9[i] = x8[i] ^ a[i];
                eb[i] = x8[i] ^ x2[i] ^ a[i];
                ed[i] = x8[i] ^ x4[i] ^ a[i];
                ee[i] = x8[i] ^ x4[i] ^ x2[i];
            end
            for (int r = 0; r < 4; r++)
                m[127 - 32*c - 8*r -: 8] = ee[r] ^ eb[(r + 1) % 4] ^ ed[(r + 2) % 4]
                                          ^ e9[(r + 3) % 4];
        end
        return m;
    endfunction

    function automatic logic [31:0] key_core(input logic [31:0] w, input byte_t rc);
        return {FWD_BOX[w[23:16]] ^ rc, FWD_BOX[w[15:8]], FWD_BOX[w[7:0]], FWD_BOX[w[31:24]]};
    endfunction

endpackage

[rtl/aes_stream_if.sv]
// Valid/ready channel interface carrying a 128-bit block word.
interface aes_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, block_high, block_low, first_block, result_high,
                    result_low, input ready);
    modport sink (input valid, block_high, block_low, first_block, result_high,
                  result_low, output ready);
endinterface

[rtl/aes_key_mem.sv]
// Round key memory: 44 words, one synchronous write and one registered read port.
module aes_key_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [aes_pkg::WordAw-1:0]  waddr,
    input  logic [31:0]                 wdata,
    input  logic [aes_pkg::WordAw-1:0]  raddr,
    output logic [31:0]                 rdata
);
    import aes_pkg::*;

    logic [31:0] mem [NumWords];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[rtl/aes128_cbc_block_cipher_top.sv]
// AES-128 CBC core: a key expansion pass fills the key memory, then rounds read it.
// Steps: a load step, then eleven rounds of four key word reads and one apply each, then
// an output step; a first block runs the key expansion of all 44 schedule words first.
// A new block is accepted only in idle, once the previous block has left the output
// stage; a waiting result holds the core only at its output stage.
// Reset clears control, configuration and chain value; key memory is undefined.
module aes128_cbc_block_cipher_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    aes_stream_if.sink        in_ch,
    aes_stream_if.source      out_ch
);
    import aes_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_LOAD, S_ROUND, S_OUT} state_t;

    state_t       state_reg;
    logic         decrypt_reg;
    logic [63:0]  key_hi_reg, key_lo_reg, iv_hi_reg, iv_lo_reg;
    logic [127:0] chain_reg, in_reg, st_reg;
    logic [31:0]  w_reg [4];      // last four schedule words
    logic [5:0]   idx_reg;        // expansion index
    logic [3:0]   rnd_reg;        // round number
    logic [1:0]   col_reg;        // column within round
    logic         rvalid_reg;     // read issued last cycle
    logic [1:0]   rcol_reg;
    logic [127:0] kacc_reg;       // round key being gathered
    logic         ovalid_reg;
    logic [127:0] res_reg;

    logic         we;
    logic [5:0]   waddr, raddr;
    logic [31:0]  wdata, rdata, wnew, tcore;
    logic [3:0]   rc_idx;
    logic [127:0] kfull, nst, rk_add;
    logic [5:0]   col_base;

    aes_key_mem u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // The result register lets the next block start while a result word waits.
    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = ovalid_reg;
    assign out_ch.result_high = res_reg[127:64];
    assign out_ch.result_low  = res_reg[63:0];
    assign out_ch.block_high  = '0;
    assign out_ch.block_low   = '0;
    assign out_ch.first_block = 1'b0;

    always_comb
    begin
        rc_idx = idx_reg[5:2] - 4'd1;
        tcore  = key_core(w_reg[3], (rc_idx < 4'd10) ? RCON[rc_idx] : 8'h00);
        wnew   = w_reg[0] ^ ((idx_reg[1:0] == 2'd0) ? tcore : w_reg[3]);
        we     = 1'b0;
        waddr  = idx_reg;
        wdata  = wnew;
        if (state_reg == S_EXPAND)
        begin
            we = 1'b1;
            if (idx_reg < 6'd4)
            begin
                unique case (idx_reg[1:0])
                    2'd0:    wdata = key_hi_reg[63:32];
                    2'd1:    wdata = key_hi_reg[31:0];
                    2'd2:    wdata = key_lo_reg[63:32];
                    default: wdata = key_lo_reg[31:0];
                endcase
            end
        end
        // Round r key word c lives at 4r+c.
        col_base = {rnd_reg, 2'b00};
        raddr    = col_base + {4'd0, col_reg};
        kfull    = kacc_reg;
        kfull[127 - 32*rcol_reg -: 32] = rdata;
        rk_add   = st_reg ^ kfull;
        if (decrypt_reg)
        begin
            if (rnd_reg == 4'd0)
                nst = rk_add;
            else if (rnd_reg == 4'd10)
                nst = rev_sub(rk_add);
            else
                nst = rev_sub(rev_mix(rk_add));
        end
        else
        begin
            if (rnd_reg == 4'd10)
                nst = rk_add;
            else
                nst = fwd_round(rk_add, rnd_reg == 4'd9);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            decrypt_reg <= 1'b0;
            key_hi_reg  <= '0;
            key_lo_reg  <= '0;
            iv_hi_reg   <= '0;
            iv_lo_reg   <= '0;
            chain_reg   <= '0;
            ovalid_reg  <= 1'b0;
            rvalid_reg  <= 1'b0;
            idx_reg     <= '0;
            rnd_reg     <= '0;
            col_reg     <= '0;
            rcol_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DECRYPT: decrypt_reg <= cfg_data[0];
                    REG_KEY_HI:  key_hi_reg  <= cfg_data;
                    REG_KEY_LO:  key_lo_reg  <= cfg_data;
                    REG_IV_HI:   iv_hi_reg   <= cfg_data;
                    REG_IV_LO:   iv_lo_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        in_reg <= {in_ch.block_high, in_ch.block_low};
                        idx_reg <= '0;
                        if (in_ch.first_block)
                        begin
                            chain_reg <= {iv_hi_reg, iv_lo_reg};
                            state_reg <= S_EXPAND;
                        end
                        else
                            state_reg <= S_LOAD;
                    end
                end
                S_EXPAND:
                begin
                    w_reg[0] <= w_reg[1];
                    w_reg[1] <= w_reg[2];
                    w_reg[2] <= w_reg[3];
                    w_reg[3] <= wdata;
                    idx_reg  <= idx_reg + 6'd1;
                    if (idx_reg == 6'(NumWords - 1))
                        state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    st_reg     <= decrypt_reg ? in_reg : (in_reg ^ chain_reg);
                    rnd_reg    <= decrypt_reg ? 4'd10 : 4'd0;
                    col_reg    <= '0;
                    rvalid_reg <= 1'b0;
                    state_reg  <= S_ROUND;
                end
                S_ROUND:
                begin
                    // Issue reads for columns 0..3; apply once column 3 returns.
                    if (!rvalid_reg || rcol_reg != 2'd3)
                    begin
                        if (rvalid_reg)
                            kacc_reg <= kfull;
                        rvalid_reg <= 1'b1;
                        rcol_reg   <= col_reg;
                        col_reg    <= col_reg + 2'd1;
                    end
                    else
                    begin
                        rvalid_reg <= 1'b0;
                        col_reg    <= '0;
                        st_reg     <= nst;
                        if (decrypt_reg ? (rnd_reg == 4'd0) : (rnd_reg == 4'd10))
                            state_reg <= S_OUT;
                        else
                            rnd_reg <= decrypt_reg ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
                    end
                end
                S_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        if (decrypt_reg)
                        begin
                            res_reg   <= st_reg ^ chain_reg;
                            chain_reg <= in_reg;
                        end
                        else
                        begin
                            res_reg   <= st_reg;
                            chain_reg <= st_reg;
                        end
                        ovalid_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
